[sv/selective_repeat_receiver_defines.svh]
// Assertion macros for the selective repeat receiver.
// Needs clk and rst in the scope of every use.
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/srr_pkg.sv]
// Shared types and constants of the selective repeat receiver.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package srr_pkg;

  localparam int SEQ_W         = 31;
  localparam int CHK_W         = 32;
  localparam int LOW_W         = 64;
  localparam int MID_W         = 64;
  localparam int HIGH_W        = 32;
  localparam int WS_W          = 4;
  localparam int PAYLOAD_BYTES = 20;
  localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
  localparam int GROUP_BYTES   = 4;
  localparam int GROUP_W       = 8 * GROUP_BYTES;
  localparam int NUM_GROUPS    = PAYLOAD_BYTES / GROUP_BYTES;
  localparam int GRP_W         = $clog2(NUM_GROUPS);

  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [CHK_W-1:0]     chk_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;

  // Result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

endpackage

`default_nettype wire

[sv/srr_pkt_if.sv]
// Packet channel: valid/ready handshake with one arriving packet per beat.
// Depends on srr_pkg.
`default_nettype none

interface srr_pkt_if;
  import srr_pkg::*;

  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    seq_num;
  logic [SEQ_W-1:0]    ack_num;
  logic signed [CHK_W-1:0] checksum;
  logic [LOW_W-1:0]    payload_low;
  logic [MID_W-1:0]    payload_mid;
  logic [HIGH_W-1:0]   payload_high;

  modport source (output valid, seq_num, ack_num, checksum,
                  output payload_low, payload_mid, payload_high, input ready);
  modport sink   (input valid, seq_num, ack_num, checksum,
                  input payload_low, payload_mid, payload_high, output ready);
endinterface

`default_nettype wire

[sv/srr_res_if.sv]
// Result channel: valid/ready handshake with one ack or delivery per beat.
// Depends on srr_pkg.
`default_nettype none

interface srr_res_if;
  import srr_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [SEQ_W-1:0]  ack_seq;
  logic [SEQ_W-1:0]  ack_check;
  logic [LOW_W-1:0]  deliver_low;
  logic [MID_W-1:0]  deliver_mid;
  logic [HIGH_W-1:0] deliver_high;
  logic              last;

  modport source (output valid, kind, ack_seq, ack_check,
                  output deliver_low, deliver_mid, deliver_high, last, input ready);
  modport sink   (input valid, kind, ack_seq, ack_check,
                  input deliver_low, deliver_mid, deliver_high, last, output ready);
endinterface

`default_nettype wire

[sv/srr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/selective_repeat_receiver.sv]
// Selective repeat receiver: an accepted packet passes capture, then the checksum sum
// (4 payload bytes a cycle) and then one result after another through the result
// register, which holds each result until it is taken; res.ready stalls the chain. A
// single checksum accumulator and a one-result output register serve every packet.
// Reset (rst, synchronous) clears the slot valid bits, sets the expected number to 1
// and the window register to 8.
`default_nettype none

module selective_repeat_receiver #(
  parameter int MAX_WINDOW = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [srr_pkg::WS_W-1:0] cfg_wr_data,
  srr_pkt_if.sink                  pkt,
  srr_res_if.source                res
);
  import srr_pkg::*;

  `include "selective_repeat_receiver_defines.svh"

  localparam int NUM_SLOTS = MAX_WINDOW + 1;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int GUARD_W   = $clog2(MAX_WINDOW + 1);

  localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [SLOT_W:0]    SLOT_COUNT  = (SLOT_W + 1)'(NUM_SLOTS);
  localparam logic [GUARD_W-1:0] GUARD_LAST  = GUARD_W'(MAX_WINDOW - 1);
  localparam seq_t               SEQ_MAX     = '1;
  localparam logic [WS_W-1:0]    WS_RESET    = WS_W'(8);
  localparam logic [GRP_W-1:0]   GRP_LAST    = GRP_W'(NUM_GROUPS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHK    = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_FIRST  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;

  logic [2:0]         state, state_next;
  logic [WS_W-1:0]    win_size;
  logic [GRP_W-1:0]   grp;
  seq_t               seq_r;
  chk_t               chk_r;
  chk_t               acc;
  payload_t           pl_r;
  logic               in_win;
  logic               is_exp;
  logic [SLOT_W-1:0]  st_slot;
  seq_t               expected_seq;
  logic [SLOT_W-1:0]  exp_slot;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [GUARD_W-1:0] guard;

  logic               out_valid;
  logic               out_kind;
  seq_t               out_seq;
  payload_t           out_pl;
  logic               out_last;

  logic               out_free;
  seq_t               win_eff;
  seq_t               diff;
  logic [SLOT_W:0]    slot_sum;
  logic [SLOT_W-1:0]  slot_calc;
  logic [SLOT_W-1:0]  nxt_slot;
  logic               nxt_empty;
  logic [GROUP_W-1:0] grp_word;
  chk_t               grp_sum;
  payload_t           rd_data;

  logic               ld_ack, ld_pl, ld_ram, ld_last, ram_we, rd_en, adv;

  assign out_free  = !out_valid || res.ready;
  assign pkt.ready = (state == ST_IDLE);

  // Clamp the window and place the packet relative to the expected number
  always_comb begin
    if (32'(win_size) > MAX_WINDOW) begin
      win_eff = SEQ_W'(MAX_WINDOW);
    end else begin
      win_eff = SEQ_W'(win_size);
    end
    diff     = seq_r - expected_seq;
    slot_sum = {1'b0, exp_slot} + {1'b0, diff[SLOT_W-1:0]};
    if (slot_sum >= SLOT_COUNT) begin
      slot_calc = SLOT_W'(slot_sum - SLOT_COUNT);
    end else begin
      slot_calc = slot_sum[SLOT_W-1:0];
    end
  end

  // Slot of the number after expected; the number wraps to zero, slot zero
  always_comb begin
    if (expected_seq == SEQ_MAX || exp_slot == LAST_SLOT) begin
      nxt_slot = '0;
    end else begin
      nxt_slot = exp_slot + SLOT_W'(1);
    end
    nxt_empty = !slot_valid[nxt_slot] || (nxt_slot == exp_slot);
  end

  // Sum one group of sign-extended payload bytes
  always_comb begin
    grp_word = pl_r[GROUP_W * grp +: GROUP_W];
    grp_sum  = '0;
    for (int i = 0; i < GROUP_BYTES; i++) begin
      grp_sum = grp_sum + {{(CHK_W - 8){grp_word[8*i+7]}}, grp_word[8*i +: 8]};
    end
  end

  // Sequencer: checksum, ack, store or deliver chain
  always_comb begin
    state_next = state;
    ld_ack     = 1'b0;
    ld_pl      = 1'b0;
    ld_ram     = 1'b0;
    ld_last    = 1'b0;
    ram_we     = 1'b0;
    rd_en      = 1'b0;
    adv        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (pkt.valid) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (grp == GRP_LAST) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (acc != chk_r) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          ld_ack     = 1'b1;
          ld_last    = !(in_win && is_exp);
          ram_we     = in_win && !is_exp;
          state_next = (in_win && is_exp) ? ST_FIRST : ST_IDLE;
        end
      end
      ST_FIRST: begin
        if (out_free) begin
          ld_pl      = 1'b1;
          adv        = 1'b1;
          ld_last    = nxt_empty;
          rd_en      = !nxt_empty;
          state_next = nxt_empty ? ST_IDLE : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          ld_ram     = 1'b1;
          adv        = 1'b1;
          ld_last    = nxt_empty || (guard == GUARD_LAST);
          rd_en      = !ld_last;
          state_next = ld_last ? ST_IDLE : ST_DRAIN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      win_size     <= WS_RESET;
      expected_seq <= SEQ_W'(1);
      exp_slot     <= SLOT_W'(1);
      slot_valid   <= '0;
      out_valid    <= 1'b0;
      grp          <= '0;
      guard        <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        win_size <= cfg_wr_data;
      end
      // advance group counter through the checksum
      if (state == ST_IDLE) begin
        grp <= '0;
      end else if (state == ST_CHK) begin
        grp <= grp + GRP_W'(1);
      end
      // mark stored slot, drop delivered slot
      if (ram_we) begin
        slot_valid[st_slot] <= 1'b1;
      end
      if (adv) begin
        slot_valid[exp_slot] <= 1'b0;
        expected_seq         <= expected_seq + SEQ_W'(1);
        exp_slot             <= nxt_slot;
      end
      if (ld_pl) begin
        guard <= '0;
      end else if (ld_ram) begin
        guard <= guard + GUARD_W'(1);
      end
      // hold a result until taken
      if (ld_ack || ld_pl || ld_ram) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Packet capture and checksum accumulation
  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      seq_r <= pkt.seq_num;
      chk_r <= chk_t'(pkt.checksum);
      pl_r  <= {pkt.payload_high, pkt.payload_mid, pkt.payload_low};
      acc   <= CHK_W'(pkt.seq_num) + CHK_W'(pkt.ack_num);
    end else if (state == ST_CHK) begin
      acc <= acc + grp_sum;
    end
    if (state == ST_CHK) begin
      in_win  <= (seq_r >= expected_seq) && (diff <= win_eff);
      is_exp  <= (seq_r == expected_seq);
      st_slot <= slot_calc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ld_ack) begin
      out_kind <= KIND_ACK;
      out_seq  <= seq_r;
      out_pl   <= '0;
      out_last <= ld_last;
    end else if (ld_pl || ld_ram) begin
      out_kind <= KIND_DELIVER;
      out_seq  <= '0;
      out_pl   <= ld_pl ? pl_r : rd_data;
      out_last <= ld_last;
    end
  end

  // Buffered payloads
  srr_ram #(
    .WIDTH (PAYLOAD_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (st_slot),
    .wr_data (pl_r),
    .rd_en   (rd_en),
    .rd_addr (nxt_slot),
    .rd_data (rd_data)
  );

  assign res.valid        = out_valid;
  assign res.kind         = out_kind;
  assign res.ack_seq      = out_seq;
  assign res.ack_check    = out_seq;
  assign res.deliver_low  = out_pl[LOW_W-1:0];
  assign res.deliver_mid  = out_pl[LOW_W +: MID_W];
  assign res.deliver_high = out_pl[LOW_W + MID_W +: HIGH_W];
  assign res.last         = out_last;

  // Checks
  `SRR_ASSERT_NOW(a_slot_range, 1'b1, exp_slot <= LAST_SLOT, "expected slot out of range")
  `SRR_ASSERT_NOW(a_ack_fields, res.valid && res.kind == KIND_ACK,
    res.ack_check == res.ack_seq && res.deliver_low == '0 && res.deliver_high == '0,
    "ack result carries payload")
  `SRR_ASSERT_NOW(a_dlv_fields, res.valid && res.kind == KIND_DELIVER,
    res.ack_seq == '0 && res.ack_check == '0, "delivery carries ack number")
  `SRR_ASSERT_NEXT(a_seq_hold, !(state == ST_FIRST || state == ST_DRAIN),
    $stable(expected_seq), "expected number moved outside delivery")
  `SRR_ASSERT_NOW(a_guard, state == ST_DRAIN, guard < GUARD_W'(MAX_WINDOW),
    "delivery chain overran window")

endmodule

`default_nettype wire

[tb/srr_tb_pkg.sv]
`timescale 1ns / 100ps
// Packet type and packet building helpers for the selective repeat receiver bench.
// Depends on srr_pkg; used by the checker and by tb_top.

package srr_tb_pkg;
  import srr_pkg::*;

  typedef struct {
    seq_t               seq;
    seq_t               ack;
    chk_t               chk;
    logic [LOW_W-1:0]   low;
    logic [MID_W-1:0]   mid;
    logic [HIGH_W-1:0]  high;
  } packet_t;

  // Wrapping 32-bit sum of seq, ack and the sign-extended payload bytes
  function automatic chk_t packet_sum(packet_t p);
    payload_t bytes;
    chk_t     acc;
    bytes = {p.high, p.mid, p.low};
    acc = {1'b0, p.seq} + {1'b0, p.ack};
    for (int i = 0; i < PAYLOAD_BYTES; i++)
      acc += {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
    return acc;
  endfunction

  // Load a payload and reseal the checksum
  function automatic packet_t with_payload(packet_t p, payload_t bytes);
    {p.high, p.mid, p.low} = bytes;
    p.chk = packet_sum(p);
    return p;
  endfunction

  // Random ack and payload; a corrupted packet gets one checksum bit flipped
  function automatic packet_t build_packet(seq_t seq, bit corrupt);
    packet_t p;
    p.seq = seq;
    p.ack = seq_t'($urandom);
    p.chk = '0;
    p = with_payload(p, {$urandom, $urandom, $urandom, $urandom, $urandom});
    if (corrupt)
      p.chk ^= chk_t'(1) << $urandom_range(CHK_W - 1, 0);
    return p;
  endfunction

endpackage

[tb/srr_checker.sv]
`timescale 1ns / 100ps
// Checker for the selective repeat receiver: tracks window, expected number and slots,
// predicts acks and deliveries per accepted packet and compares each result beat.
// Depends on srr_pkg, srr_tb_pkg and the two channel interfaces.

module srr_checker
  import srr_pkg::*;
  import srr_tb_pkg::*;
#(
  parameter int MAX_WINDOW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [WS_W-1:0] cfg_wr_data,
  srr_pkt_if              pkt,
  srr_res_if              res,
  output int              errors,
  output int              owed
);

  localparam int SLOTS           = MAX_WINDOW + 1;
  localparam int WINDOW_AT_RESET = 8;
  localparam int PRINT_CAP       = 40;

  typedef struct {
    logic              kind;
    seq_t              ack_seq;
    seq_t              ack_check;
    logic [LOW_W-1:0]  low;
    logic [MID_W-1:0]  mid;
    logic [HIGH_W-1:0] high;
    logic              last;
  } result_beat_t;

  logic [WS_W-1:0] window_reg;
  seq_t            next_seq;
  logic            slot_held [SLOTS];
  payload_t        slot_bytes [SLOTS];
  result_beat_t    results_due [$];

  initial errors = 0;

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  function automatic void queue_result(logic kind, seq_t seq, payload_t bytes);
    result_beat_t r;
    r.kind      = kind;
    r.ack_seq   = seq;
    r.ack_check = seq;
    {r.high, r.mid, r.low} = bytes;
    r.last      = 1'b0;
    results_due.insert(results_due.size(), r);
  endfunction

  // Ack, then store or deliver along with any consecutive buffered payloads
  task automatic absorb_packet(input packet_t p);
    payload_t       bytes;
    logic [SEQ_W:0] win;
    int             slot;
    int             guard;
    bytes = {p.high, p.mid, p.low};
    // drop a packet with a bad checksum
    if (packet_sum(p) != p.chk) return;
    queue_result(KIND_ACK, p.seq, '0);
    if (window_reg > MAX_WINDOW) win = (SEQ_W + 1)'(MAX_WINDOW);
    else win = (SEQ_W + 1)'(window_reg);
    if (p.seq >= next_seq && {1'b0, p.seq} <= {1'b0, next_seq} + win) begin
      if (p.seq != next_seq) begin
        slot = p.seq % SLOTS;
        slot_held[slot]  = 1'b1;
        slot_bytes[slot] = bytes;
      end else begin
        slot_held[p.seq % SLOTS] = 1'b0;
        queue_result(KIND_DELIVER, '0, bytes);
        next_seq = next_seq + 1'b1;
        guard = 0;
        // drain the run of buffered successors
        while (guard < MAX_WINDOW && slot_held[next_seq % SLOTS]) begin
          slot = next_seq % SLOTS;
          queue_result(KIND_DELIVER, '0, slot_bytes[slot]);
          slot_held[slot] = 1'b0;
          next_seq = next_seq + 1'b1;
          guard++;
        end
      end
    end
    results_due[results_due.size() - 1].last = 1'b1;
  endtask

  task automatic check_result();
    result_beat_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing outstanding, kind %0d", res.kind));
      return;
    end
    want = results_due[0];
    results_due.delete(0);
    check_field("kind", res.kind, want.kind);
    check_field("ack_seq", res.ack_seq, want.ack_seq);
    check_field("ack_check", res.ack_check, want.ack_check);
    check_field("deliver_low", res.deliver_low, want.low);
    check_field("deliver_mid", res.deliver_mid, want.mid);
    check_field("deliver_high", res.deliver_high, want.high);
    check_field("last", res.last, want.last);
  endtask

  // Sample both channels and the config port at every edge
  always @(posedge clk) begin
    packet_t p;
    if (rst) begin
      window_reg = WS_W'(WINDOW_AT_RESET);
      next_seq   = SEQ_W'(1);
      foreach (slot_held[i]) slot_held[i] = 1'b0;
      results_due.delete();
    end else begin
      if (cfg_wr_en)
        window_reg = cfg_wr_data;
      if (pkt.valid && pkt.ready) begin
        p.seq  = pkt.seq_num;
        p.ack  = pkt.ack_num;
        p.chk  = pkt.checksum;
        p.low  = pkt.payload_low;
        p.mid  = pkt.payload_mid;
        p.high = pkt.payload_high;
        absorb_packet(p);
      end
      if (res.valid && res.ready)
        check_result();
    end
    owed <= results_due.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the selective repeat receiver bench: clock, reset, packet and config stimulus,
// result back-pressure and the verdict. Depends on srr_pkg, srr_tb_pkg and srr_checker.

module tb_top;
  import srr_pkg::*;
  import srr_tb_pkg::*;

  localparam int MAX_WINDOW   = 8;
  localparam int DRAIN_CYCLES = 2 * (MAX_WINDOW + 8);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 270;
  localparam int PHASE_ITEMS  = 45;
  localparam int LONG_HOLD    = 400;

  typedef enum {RX_OPEN, RX_RANDOM, RX_STALL, RX_TOGGLE} rx_mode_t;
  typedef enum {NOISE_CORRUPT, NOISE_STALE, NOISE_FAR} noise_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_wr_en;
  logic [WS_W-1:0] cfg_wr_data;
  int              failures;
  int              owed;
  int              cycles;
  int              hold_ask = 0;
  int              burst_left = 0;
  int              useful_sent = 0;
  seq_t            base;

  srr_pkt_if pkt_ch ();
  srr_res_if res_ch ();

  selective_repeat_receiver #(.MAX_WINDOW(MAX_WINDOW)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pkt         (pkt_ch),
    .res         (res_ch)
  );

  srr_checker #(.MAX_WINDOW(MAX_WINDOW)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pkt         (pkt_ch),
    .res         (res_ch),
    .errors      (failures),
    .owed        (owed)
  );

  always #5 clk = ~clk;

  // Offer one packet; bursts of random length with random gaps in between
  task automatic offer_packet(input packet_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        pkt_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pkt_ch.seq_num      <= p.seq;
    pkt_ch.ack_num      <= p.ack;
    pkt_ch.checksum     <= p.chk;
    pkt_ch.payload_low  <= p.low;
    pkt_ch.payload_mid  <= p.mid;
    pkt_ch.payload_high <= p.high;
    pkt_ch.valid        <= 1'b1;
    do @(posedge clk); while (!pkt_ch.ready);
  endtask

  // Drop valid, wait for every outstanding result, then let the block go quiet
  task automatic settle();
    pkt_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WS_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Out-of-order junk between good packets: bad checksum, stale seq, or far ahead
  task automatic offer_noise();
    seq_t far;
    case (noise_t'($urandom_range(0, 2)))
      NOISE_CORRUPT:
        offer_packet(build_packet(seq_t'(base + $urandom_range(0, MAX_WINDOW)), 1'b1));
      NOISE_STALE: begin
        offer_packet(build_packet(seq_t'($urandom_range(0, base - 1)), 1'b0));
        useful_sent++;
      end
      default: begin
        far = seq_t'($urandom);
        if (far < base + 1000) far = seq_t'(far + base + 1000);
        offer_packet(build_packet(far, 1'b0));
        useful_sent++;
      end
    endcase
  endtask

  // Rounds of up to one full window in shuffled order, so every round drains completely
  task automatic run_rounds(input int target, input int window);
    seq_t order [MAX_WINDOW + 1];
    seq_t tmp;
    int   span;
    int   k;
    int   j;
    span = (window > MAX_WINDOW) ? MAX_WINDOW : window;
    while (useful_sent < target) begin
      k = $urandom_range(1, span + 1);
      for (int i = 0; i < k; i++) order[i] = seq_t'(base + i);
      for (int i = k - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      // just past the window edge: ack only
      if ($urandom_range(0, 3) == 0) begin
        offer_packet(build_packet(seq_t'(base + span + 1), 1'b0));
        useful_sent++;
      end
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 5) == 0) offer_noise();
        offer_packet(build_packet(order[i], 1'b0));
        useful_sent++;
        if ($urandom_range(0, 7) == 0) begin
          offer_packet(build_packet(order[i], 1'b0));
          useful_sent++;
        end
      end
      base = seq_t'(base + k);
    end
  endtask

  // Result back-pressure: open, random, stall and toggle segments, plus the long hold
  initial begin
    rx_mode_t mode;
    int       seg;
    int       hold_seen;
    hold_seen = 0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      seg  = $urandom_range(1, 30);
      for (int i = 0; i < seg; i++) begin
        case (mode)
          RX_OPEN:   res_ch.ready <= 1'b1;
          RX_RANDOM: res_ch.ready <= 1'($urandom_range(0, 1));
          RX_STALL:  res_ch.ready <= (i >= 8);
          default:   res_ch.ready <= i[0];
        endcase
        @(posedge clk);
      end
    end
  end

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Main stimulus
  initial begin
    packet_t          p;
    logic [WS_W-1:0]  windows [6];
    logic [WS_W-1:0]  w;
    int               phase;
    windows = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd5, 4'd3};
    pkt_ch.valid        <= 1'b0;
    pkt_ch.seq_num      <= '0;
    pkt_ch.ack_num      <= '0;
    pkt_ch.checksum     <= '0;
    pkt_ch.payload_low  <= '0;
    pkt_ch.payload_mid  <= '0;
    pkt_ch.payload_high <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset window of 8, expected number starts at 1
    // below the window: ack only
    offer_packet(build_packet('0, 1'b0));
    // largest seq and ack, all-ones payload: ack only
    p = build_packet('1, 1'b0);
    p.ack = '1;
    offer_packet(with_payload(p, '1));
    // bad checksum on the expected number: silently dropped
    offer_packet(build_packet(1, 1'b1));
    // one past the window edge: ack only
    offer_packet(build_packet(10, 1'b0));
    // expected number with zero ack and zero payload: immediate delivery
    p = build_packet(1, 1'b0);
    p.ack = '0;
    offer_packet(with_payload(p, '0));
    // buffer 4, overwrite it with a duplicate, buffer 3 with sign-edge bytes
    offer_packet(build_packet(4, 1'b0));
    offer_packet(build_packet(4, 1'b0));
    offer_packet(with_payload(build_packet(3, 1'b0), {10{16'h807f}}));
    // fill the gap: delivers 2, 3, 4
    offer_packet(build_packet(2, 1'b0));
    // fill the whole window down from its far edge, then release all of it at once
    for (int s = 13; s >= 6; s--) offer_packet(build_packet(seq_t'(s), 1'b0));
    offer_packet(build_packet(5, 1'b0));
    base = 14;

    // Random phases, one window setting each; long receiver hold in the second
    phase = 0;
    while (useful_sent < RANDOM_ITEMS) begin
      settle();
      w = (phase < 6) ? windows[phase] : WS_W'($urandom_range(0, 15));
      write_window(w);
      if (phase == 1) hold_ask++;
      run_rounds(useful_sent + PHASE_ITEMS, w);
      phase++;
    end

    settle();
    if (failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
